// File: hw/rtl/scbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// shared types and constants of the size class buffer pool
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int unsigned LEN_W       = 14;  // request and stored length
  localparam int unsigned ID_OUT_W    = 6;   // buffer id on the result port
  localparam int unsigned MAX_CLASSES = 8;   // upper bound of the class count
  localparam int unsigned SH_W        = 8;   // class log2 size, up to 15 + 7 * 7

  // command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // register indexes
  localparam logic REG_SMALLEST = 1'b0;
  localparam logic REG_STEP     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_BUF = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PUSH,
    B_FETCH
  } back_state_e;

  // classified command word handed from front to back
  typedef struct packed {
    logic                   cmd;
    logic [LEN_W-1:0]       len;
    logic                   len_ok;
    logic [MAX_CLASSES-1:0] fit;
  } cmd_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/scbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/scbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_front
// accepts commands, works out the fitting classes and queues the word
// ----------------------------------------------------------------------------
module scbp_front #(
  parameter int unsigned NUM_CLASSES = 6,
  parameter int unsigned MAX_LENGTH  = 8192
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]  req_length_i,
  input  wire logic [3:0]                  smallest_i,
  input  wire logic [2:0]                  step_i,
  output scbp_pkg::cmd_word_t              word_o,
  output logic                             valid_o,
  input  wire logic                        pop_i
);

  localparam int unsigned CMP_W = 17;

  scbp_pkg::cmd_word_t word_in;
  scbp_pkg::cmd_word_t ent_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          fill_q, fill_d;
  logic                push;

  // class k fits when its size reaches the request; 2^14 and up fit any length
  always_comb begin
    logic [scbp_pkg::SH_W-1:0] sh;
    sh = '0;
    word_in.cmd    = cmd_i;
    word_in.len    = req_length_i;
    word_in.len_ok = CMP_W'(req_length_i) <= CMP_W'(MAX_LENGTH);
    word_in.fit    = '0;
    for (int k = 0; k < int'(scbp_pkg::MAX_CLASSES); k++) begin
      if (k < int'(NUM_CLASSES)) begin
        sh = scbp_pkg::SH_W'(smallest_i)
           + scbp_pkg::SH_W'(k) * scbp_pkg::SH_W'(step_i);
        word_in.fit[k] = (sh >= scbp_pkg::SH_W'(scbp_pkg::LEN_W))
                      || ((15'd1 << sh[3:0]) >= {1'b0, req_length_i});
      end
    end
  end

  assign busy    = (fill_q == 2'd2);
  assign push    = start && !busy;
  assign valid_o = (fill_q != 2'd0);
  assign word_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= word_in;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_back
// executes queued words against the free stacks and the descriptor fifo
// ----------------------------------------------------------------------------
module scbp_back #(
  parameter int unsigned NUM_CLASSES     = 6,
  parameter int unsigned SLOTS_PER_CLASS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire scbp_pkg::cmd_word_t           word_i,
  input  wire logic                          valid_i,
  output logic                               pop_o,
  output logic                               done_o,
  output scbp_pkg::status_e                  status_o,
  output logic [scbp_pkg::ID_OUT_W-1:0]      buffer_id_o,
  output logic [scbp_pkg::LEN_W-1:0]         length_out_o
);

  localparam int unsigned TOTAL = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int unsigned IDW   = $clog2(TOTAL > 1 ? TOTAL : 2);
  localparam int unsigned SW    = $clog2(SLOTS_PER_CLASS + 1);
  localparam int unsigned QW    = $clog2(TOTAL + 1);
  localparam int unsigned CW    = $clog2(NUM_CLASSES > 1 ? NUM_CLASSES : 2);
  localparam int unsigned LW    = scbp_pkg::LEN_W;
  localparam int unsigned FW    = IDW + LW;

  scbp_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]  count_q [NUM_CLASSES];
  logic [SW-1:0]  count_d [NUM_CLASSES];
  logic [SW-1:0]  lw_q    [NUM_CLASSES];  // lowest fill ever seen per class
  logic [SW-1:0]  lw_d    [NUM_CLASSES];
  logic [IDW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QW-1:0]  queued_q, queued_d;

  logic [LW-1:0]  cur_len_q, cur_len_d;
  logic           cur_pristine_q, cur_pristine_d;
  logic [IDW-1:0] cur_reset_id_q, cur_reset_id_d;

  logic              done_q, done_d;
  scbp_pkg::status_e status_q, status_d;
  logic [IDW-1:0]    id_q, id_d;
  logic [LW-1:0]     len_q, len_d;

  logic           stk_we, stk_re;
  logic [IDW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic           fifo_we, fifo_re;
  logic [IDW-1:0] fifo_waddr, fifo_raddr;
  logic [FW-1:0]  fifo_wdata, fifo_rdata;

  logic [NUM_CLASSES-1:0] avail;
  logic                   found;
  logic [CW-1:0]          pick_k;
  logic [SW-1:0]          newc;
  logic [IDW-1:0]         f_id, g_id;
  logic [LW-1:0]          f_len;
  logic [CW-1:0]          f_k;
  logic                   f_valid;

  // free stacks, class k at rows k*SLOTS_PER_CLASS upward
  scbp_ram #(.WIDTH(IDW), .DEPTH(TOTAL)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // descriptor fifo of {id, length}
  scbp_ram #(.WIDTH(FW), .DEPTH(TOTAL)) u_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  // lowest fitting class with a free buffer
  always_comb begin
    found  = 1'b0;
    pick_k = '0;
    for (int k = 0; k < int'(NUM_CLASSES); k++) begin
      avail[k] = word_i.fit[k] && (count_q[k] != '0);
    end
    for (int k = int'(NUM_CLASSES) - 1; k >= 0; k--) begin
      if (avail[k]) begin
        found  = 1'b1;
        pick_k = CW'(k);
      end
    end
    newc = count_q[pick_k] - SW'(1);
  end

  // owning class of a fetched id
  always_comb begin
    f_id    = fifo_rdata[FW-1:LW];
    f_len   = fifo_rdata[LW-1:0];
    f_valid = {1'b0, f_id} < (IDW + 1)'(TOTAL);
    f_k     = '0;
    for (int k = 1; k < int'(NUM_CLASSES); k++) begin
      if (f_id >= IDW'(k * SLOTS_PER_CLASS)) begin
        f_k = CW'(k);
      end
    end
    g_id = cur_pristine_q ? cur_reset_id_q : stk_rdata;
  end

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    lw_d           = lw_q;
    head_d         = head_q;
    tail_d         = tail_q;
    queued_d       = queued_q;
    cur_len_d      = cur_len_q;
    cur_pristine_d = cur_pristine_q;
    cur_reset_id_d = cur_reset_id_q;
    done_d         = 1'b0;
    status_d       = status_q;
    id_d           = id_q;
    len_d          = len_q;
    pop_o          = 1'b0;
    stk_re         = 1'b0;
    stk_raddr      = IDW'(pick_k) * IDW'(SLOTS_PER_CLASS) + IDW'(newc);
    stk_we         = 1'b0;
    stk_waddr      = IDW'(f_k) * IDW'(SLOTS_PER_CLASS) + IDW'(count_q[f_k]);
    stk_wdata      = f_id;
    fifo_re        = 1'b0;
    fifo_raddr     = head_q;
    fifo_we        = 1'b0;
    fifo_waddr     = tail_q;
    fifo_wdata     = {g_id, cur_len_q};

    unique case (state_q)
      scbp_pkg::B_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          if (word_i.cmd == scbp_pkg::CMD_PUSH) begin
            if (found && word_i.len_ok && (queued_q < QW'(TOTAL))) begin
              stk_re          = 1'b1;
              count_d[pick_k] = newc;
              cur_len_d       = word_i.len;
              cur_pristine_d  = newc < lw_q[pick_k];
              cur_reset_id_d  = IDW'(pick_k) * IDW'(SLOTS_PER_CLASS)
                              + IDW'(SLOTS_PER_CLASS - 1) - IDW'(newc);
              if (newc < lw_q[pick_k]) begin
                lw_d[pick_k] = newc;
              end
              state_d = scbp_pkg::B_PUSH;
            end else begin
              done_d   = 1'b1;
              status_d = scbp_pkg::ST_NO_BUF;
              id_d     = '0;
              len_d    = word_i.len;
            end
          end else begin
            if (queued_q == '0) begin
              done_d   = 1'b1;
              status_d = scbp_pkg::ST_EMPTY;
              id_d     = '0;
              len_d    = '0;
            end else begin
              fifo_re  = 1'b1;
              head_d   = (head_q == IDW'(TOTAL - 1)) ? '0 : head_q + IDW'(1);
              queued_d = queued_q - QW'(1);
              state_d  = scbp_pkg::B_FETCH;
            end
          end
        end
      end
      scbp_pkg::B_PUSH: begin
        fifo_we  = 1'b1;
        tail_d   = (tail_q == IDW'(TOTAL - 1)) ? '0 : tail_q + IDW'(1);
        queued_d = queued_q + QW'(1);
        done_d   = 1'b1;
        status_d = scbp_pkg::ST_OK;
        id_d     = g_id;
        len_d    = cur_len_q;
        state_d  = scbp_pkg::B_IDLE;
      end
      scbp_pkg::B_FETCH: begin
        if (f_valid && (count_q[f_k] < SW'(SLOTS_PER_CLASS))) begin
          stk_we       = 1'b1;
          count_d[f_k] = count_q[f_k] + SW'(1);
        end
        done_d   = 1'b1;
        status_d = scbp_pkg::ST_OK;
        id_d     = f_id;
        len_d    = f_len;
        state_d  = scbp_pkg::B_IDLE;
      end
      default: begin
        state_d = scbp_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scbp_pkg::B_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      queued_q <= '0;
      done_q   <= 1'b0;
      for (int k = 0; k < int'(NUM_CLASSES); k++) begin
        count_q[k] <= SW'(SLOTS_PER_CLASS);
        lw_q[k]    <= SW'(SLOTS_PER_CLASS);
      end
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      queued_q <= queued_d;
      done_q   <= done_d;
      count_q  <= count_d;
      lw_q     <= lw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_len_q      <= cur_len_d;
    cur_pristine_q <= cur_pristine_d;
    cur_reset_id_q <= cur_reset_id_d;
    status_q       <= status_d;
    id_q           <= id_d;
    len_q          <= len_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign buffer_id_o  = scbp_pkg::ID_OUT_W'(id_q);
  assign length_out_o = len_q;

  a_queued_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q <= QW'(TOTAL))
    else $error("descriptor fifo over its depth");

  a_work_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != scbp_pkg::B_IDLE |=> state_q == scbp_pkg::B_IDLE)
    else $error("back end stayed busy past one working cycle");

  a_push_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scbp_pkg::B_PUSH |=> done_q && status_q == scbp_pkg::ST_OK)
    else $error("granted push gave no ok result");

  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == scbp_pkg::B_IDLE && valid_i)
    else $error("queue popped while back end busy or queue empty");

endmodule
`default_nettype wire

// File: hw/rtl/size_class_buffer_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_buffer_pool
// buffer descriptor manager with segregated size classes and a descriptor fifo
// ----------------------------------------------------------------------------
// commands enter on start/cmd_i/req_length_i and are taken at an edge with
// start high and busy low. a push (cmd 0) grants the most recently freed
// buffer of the smallest fitting class that has one free and queues {id,
// length}; a fetch (cmd 1) pops the oldest descriptor and frees its buffer.
// one result word per command appears on status_o/buffer_id_o/length_out_o
// for exactly one cycle with done_o high; the receiver cannot stall it.
// a rejected push or an empty fetch is answered straight from the idle state;
// a granted push or a fetch first passes the push or fetch state, for the
// registered read of the free stack or fifo ram, and keeps the back end
// occupied there; a 2-word queue lets new commands in while the back end
// works, busy marks it full.
// class sizes come from two apb registers (smallest size log2 at 0x0, step
// log2 at 0x4); write them only while the block is idle, which it does not
// enforce. after reset all classes are full and the fifo is empty; no clearing
// pass is needed, untouched stack rows are served from their reset ids
// ----------------------------------------------------------------------------
module size_class_buffer_pool #(
  parameter int unsigned NUM_CLASSES     = 6,
  parameter int unsigned SLOTS_PER_CLASS = 10,
  parameter int unsigned MAX_LENGTH      = 8192
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]  req_length_i,
  // result channel
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [scbp_pkg::ID_OUT_W-1:0]    buffer_id_o,
  output logic [scbp_pkg::LEN_W-1:0]       length_out_o,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [3:0]          smallest_q;
  logic [2:0]          step_q;
  logic                cfg_wr;
  scbp_pkg::cmd_word_t word;
  logic                word_valid;
  logic                word_pop;
  scbp_pkg::status_e   status;

  // register write on the access phase, pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smallest_q <= 4'd3;
      step_q     <= 3'd2;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        scbp_pkg::REG_SMALLEST: smallest_q <= pwdata[3:0];
        scbp_pkg::REG_STEP:     step_q     <= pwdata[2:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      scbp_pkg::REG_SMALLEST: prdata = {28'd0, smallest_q};
      scbp_pkg::REG_STEP:     prdata = {29'd0, step_q};
      default:                prdata = '0;
    endcase
  end

  // front: accept and classify, 2-word queue
  scbp_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .req_length_i (req_length_i),
    .smallest_i   (smallest_q),
    .step_i       (step_q),
    .word_o       (word),
    .valid_o      (word_valid),
    .pop_i        (word_pop)
  );

  // back: free stacks, descriptor fifo, result register
  scbp_back #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word),
    .valid_i      (word_valid),
    .pop_o        (word_pop),
    .done_o       (done_o),
    .status_o     (status),
    .buffer_id_o  (buffer_id_o),
    .length_out_o (length_out_o)
  );

  assign status_o = status;

endmodule
`default_nettype wire

// File: sim/size_class_buffer_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_pool_tb
// self-checking bench for the size class buffer pool: commands go in through
// a queued driver, every result word is checked against an in-bench model of
// the free stacks and the descriptor fifo, class sizes are changed between
// phases over the register port
// ----------------------------------------------------------------------------
module size_class_buffer_pool_tb;

  localparam int unsigned N_CLASSES   = 6;
  localparam int unsigned N_SLOTS     = 10;
  localparam int unsigned N_BUFS      = N_CLASSES * N_SLOTS;
  localparam int unsigned LEN_LIMIT   = 8192;
  localparam int unsigned LEN_ALL     = (1 << scbp_pkg::LEN_W) - 1;
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no traffic at all
  localparam int unsigned PHASE_ITEMS = 203;

  typedef struct packed {
    logic                       cmd;
    logic [scbp_pkg::LEN_W-1:0] len;
  } pool_cmd_t;

  typedef struct packed {
    scbp_pkg::status_e             status;
    logic [scbp_pkg::ID_OUT_W-1:0] id;
    logic [scbp_pkg::LEN_W-1:0]    len;
  } pool_word_t;

  // dut signals, all inputs known from time zero
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          start        = 1'b0;
  logic                          cmd_i        = scbp_pkg::CMD_PUSH;
  logic [scbp_pkg::LEN_W-1:0]    req_length_i = '0;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [2:0]                    paddr        = '0;
  logic [31:0]                   pwdata       = '0;
  logic                          busy;
  logic                          done_o;
  logic [1:0]                    status_o;
  logic [scbp_pkg::ID_OUT_W-1:0] buffer_id_o;
  logic [scbp_pkg::LEN_W-1:0]    length_out_o;
  logic [31:0]                   prdata;
  logic                          pready;

  size_class_buffer_pool #(
    .NUM_CLASSES    (N_CLASSES),
    .SLOTS_PER_CLASS(N_SLOTS),
    .MAX_LENGTH     (LEN_LIMIT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .req_length_i(req_length_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .buffer_id_o (buffer_id_o),
    .length_out_o(length_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pool model: per-class free stacks, descriptor fifo, class size registers
  // ---------------------------------------------------------------------------
  int unsigned                   cfg_smallest;
  int unsigned                   cfg_step;
  logic [scbp_pkg::ID_OUT_W-1:0] free_ids [N_CLASSES][N_SLOTS];
  int unsigned                   free_depth [N_CLASSES];
  logic [scbp_pkg::ID_OUT_W-1:0] desc_id [N_BUFS];
  logic [scbp_pkg::LEN_W-1:0]    desc_len [N_BUFS];
  int unsigned                   desc_head;
  int unsigned                   desc_tail;
  int unsigned                   desc_count;

  pool_cmd_t  cmd_backlog[$];     // commands waiting for the driver
  pool_word_t expected_words[$];  // predicted result words, oldest first

  int unsigned err_count    = 0;
  int unsigned n_granted    = 0;
  int unsigned n_no_buf     = 0;
  int unsigned n_freed      = 0;
  int unsigned n_empty      = 0;
  int unsigned n_settings   = 0;
  int unsigned words_taken  = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void reset_pool_model();
    cfg_smallest = 3;
    cfg_step     = 2;
    for (int k = 0; k < N_CLASSES; k++) begin
      // lowest id on top of each stack
      for (int i = 0; i < N_SLOTS; i++)
        free_ids[k][i] = scbp_pkg::ID_OUT_W'(k * N_SLOTS + (N_SLOTS - 1 - i));
      free_depth[k] = N_SLOTS;
    end
    desc_head  = 0;
    desc_tail  = 0;
    desc_count = 0;
  endfunction

  function automatic bit class_fits(input int unsigned k, input int unsigned len);
    int unsigned sh;
    sh = cfg_smallest + k * cfg_step;
    // huge class exponents take anything
    if (sh >= 20) return 1'b1;
    return (32'd1 << sh) >= len;
  endfunction

  function automatic pool_word_t predict_pool_cmd(input pool_cmd_t c);
    pool_word_t  w;
    bit          found;
    int unsigned k;
    w     = '{status: scbp_pkg::ST_OK, id: '0, len: '0};
    found = 1'b0;
    if (c.cmd == scbp_pkg::CMD_PUSH) begin
      w.len = c.len;
      if (c.len <= LEN_LIMIT && desc_count < N_BUFS) begin
        // classes tried in index order, first fit wins
        for (k = 0; k < N_CLASSES && !found; k++) begin
          if (free_depth[k] > 0 && class_fits(k, c.len)) begin
            free_depth[k]--;
            w.id  = free_ids[k][free_depth[k]];
            found = 1'b1;
          end
        end
      end
      if (found) begin
        desc_id[desc_tail]  = w.id;
        desc_len[desc_tail] = c.len;
        desc_tail = (desc_tail + 1) % N_BUFS;
        desc_count++;
        n_granted++;
      end else begin
        // no buffer granted: state untouched
        w.status = scbp_pkg::ST_NO_BUF;
        n_no_buf++;
      end
    end else if (desc_count == 0) begin
      w.status = scbp_pkg::ST_EMPTY;
      n_empty++;
    end else begin
      w.id  = desc_id[desc_head];
      w.len = desc_len[desc_head];
      desc_head = (desc_head + 1) % N_BUFS;
      desc_count--;
      k = w.id / N_SLOTS;
      if (k < N_CLASSES && free_depth[k] < N_SLOTS) begin
        free_ids[k][free_depth[k]] = w.id;
        free_depth[k]++;
      end
      n_freed++;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic cmd, input int unsigned len);
    cmd_backlog.push_back('{cmd: cmd, len: scbp_pkg::LEN_W'(len)});
  endtask

  // lengths aimed at the current class boundaries, plus plain spreads
  function automatic int unsigned pick_length();
    int unsigned pick;
    int unsigned sh;
    int unsigned sz;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return LEN_LIMIT;
        2: return $urandom_range(LEN_LIMIT + 1, LEN_ALL);
        default: return $urandom_range(0, LEN_ALL);
      endcase
    end else if (pick < 55) begin
      sh = cfg_smallest + $urandom_range(0, N_CLASSES - 1) * cfg_step;
      sz = (sh >= scbp_pkg::LEN_W) ? LEN_ALL : (1 << sh);
      case ($urandom_range(0, 2))
        0: return sz;
        1: return (sz < LEN_ALL) ? sz + 1 : sz;
        default: return $urandom_range(0, sz);
      endcase
    end else begin
      sz = 1 << $urandom_range(0, 13);
      return $urandom_range(sz / 2, sz);
    end
  endfunction

  // bursts that fill the pool, drain it, or mix, with some raw noise
  task automatic queue_random_phase(input int unsigned n);
    int unsigned done_n;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned kind;
    done_n = 0;
    while (done_n < n) begin
      kind  = $urandom_range(0, 9);
      burst = $urandom_range(4, 40);
      if (kind < 4)      push_pct = 85;
      else if (kind < 7) push_pct = 15;
      else               push_pct = 50;
      for (int i = 0; i < burst && done_n < n; i++) begin
        if (kind == 9)
          queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, LEN_ALL));
        else if ($urandom_range(0, 99) < push_pct)
          queue_cmd(scbp_pkg::CMD_PUSH, pick_length());
        else
          queue_cmd(scbp_pkg::CMD_FETCH, $urandom_range(0, LEN_ALL));
        done_n++;
      end
    end
  endtask

  // wait until every word has been returned, then let the back end settle
  task automatic drain_pool();
    while (cmd_backlog.size() != 0 || expected_words.size() != 0 || start)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write with junk above the register width, then read back
  task automatic write_pool_reg(input logic idx, input int unsigned value);
    logic [31:0] mask;
    mask = (idx == scbp_pkg::REG_SMALLEST) ? 32'hF : 32'h7;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (32'($urandom()) & ~mask) | (value & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == scbp_pkg::REG_SMALLEST) cfg_smallest = value & mask;
    else                               cfg_step     = value & mask;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask))
      report_mismatch("register readback", prdata, value & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the backlog head, holds it until taken, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit gap;
    if (rst_ni) begin
      // the word on the port was taken at this edge
      if (start && !busy) begin
        expected_words.push_back(predict_pool_cmd(cmd_backlog.pop_front()));
        words_taken++;
      end
      if (!(start && busy)) begin
        // long gap-free stretch in the middle of the run
        gap = (words_taken < 700 || words_taken > 1000) && ($urandom_range(0, 99) < 26);
        if (cmd_backlog.size() != 0 && !gap) begin
          start        <= 1'b1;
          cmd_i        <= cmd_backlog[0].cmd;
          req_length_i <= cmd_backlog[0].len;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pool_word_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none pending, status", status_o, 0);
      end else begin
        want = expected_words.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (buffer_id_o !== want.id)
          report_mismatch("buffer id", buffer_id_o, want.id);
        if (length_out_o !== want.len)
          report_mismatch("length", length_out_o, want.len);
      end
    end
  end

  // watchdog: cycles with no command taken, no result and no register access
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no traffic for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence: directed words, then random phases under several class layouts
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned set_smallest [8];
    int unsigned set_step [8];
    set_smallest = '{0, 13, 0, 13, 2, 5, 0, 0};
    set_step     = '{0, 4, 4, 0, 1, 3, 0, 0};
    set_smallest[6] = $urandom_range(0, 13);
    set_step[6]     = $urandom_range(0, 4);
    set_smallest[7] = $urandom_range(0, 13);
    set_step[7]     = $urandom_range(0, 4);
    reset_pool_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset layout: 8, 32, 128, 512, 2048, 8192 bytes
    queue_cmd(scbp_pkg::CMD_FETCH, LEN_ALL);       // fetch from an empty queue
    queue_cmd(scbp_pkg::CMD_PUSH, 0);
    queue_cmd(scbp_pkg::CMD_PUSH, LEN_LIMIT);      // largest class
    queue_cmd(scbp_pkg::CMD_PUSH, LEN_LIMIT + 1);  // over the length limit
    queue_cmd(scbp_pkg::CMD_PUSH, LEN_ALL);
    queue_cmd(scbp_pkg::CMD_PUSH, 8);              // exact fit
    queue_cmd(scbp_pkg::CMD_PUSH, 9);              // one past a boundary
    queue_cmd(scbp_pkg::CMD_PUSH, 33);
    queue_cmd(scbp_pkg::CMD_PUSH, 2048);
    queue_cmd(scbp_pkg::CMD_PUSH, 2049);
    // empty class 0 and spill into class 1
    for (int i = 0; i < 9; i++) queue_cmd(scbp_pkg::CMD_PUSH, 5);
    for (int i = 0; i < 6; i++) queue_cmd(scbp_pkg::CMD_FETCH, i * 1000);
    queue_random_phase(PHASE_ITEMS);

    for (int p = 0; p < 8; p++) begin
      drain_pool();
      write_pool_reg(scbp_pkg::REG_SMALLEST, set_smallest[p]);
      write_pool_reg(scbp_pkg::REG_STEP, set_step[p]);
      queue_random_phase(PHASE_ITEMS);
    end

    drain_pool();
    repeat (8) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch("result words never returned", 0, expected_words.size());
    $display("covered %0d commands over %0d register writes", words_taken, n_settings);
    $display("grants %0d, no-fit %0d, fetches %0d, empty fetches %0d",
             n_granted, n_no_buf, n_freed, n_empty);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
